// ===== design/stp_pkg.sv =====
// shared types, constants and codes for the software timer pool
package stp_pkg;

    // pool size and shared counter width
    localparam int NUM_TIMERS  = 26;
    localparam int COUNT_WIDTH = 16;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 5;
    localparam int ELAPSED_W = 16;
    localparam int MAXTICS_W = 16;

    localparam logic [MAXTICS_W-1:0] MAX_TICS_RESET = 16'd30000;

    // derived widths
    localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CMP_W     = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;
    localparam int MT_CMP_W  = (COUNT_WIDTH > MAXTICS_W) ? COUNT_WIDTH : MAXTICS_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RESTART = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POST
    } state_t;

    // contents of one timer cell
    typedef struct packed {
        logic                   used;
        logic [COUNT_WIDTH-1:0] mark;
    } cell_t;

    // per-step control from the sequencer to the head unit
    typedef struct packed {
        logic                   start;
        logic                   step;
        op_t                    op;
        logic [HANDLE_W-1:0]    handle;
        logic [IDX_W-1:0]       idx;
        logic                   rebase;
        logic [COUNT_WIDTH-1:0] rebase_amt;
        logic [COUNT_WIDTH-1:0] count;
    } walk_ctrl_t;

    // collected result of one walk
    typedef struct packed {
        logic                 status;
        logic [HANDLE_W-1:0]  granted_handle;
        logic [ELAPSED_W-1:0] elapsed;
    } result_t;

endpackage

// ===== design/stp_req_if.sv =====
// request channel carrying one timer operation
interface stp_req_if;
    logic                         valid;
    logic                         ready;
    logic [stp_pkg::OP_W-1:0]     operation;
    logic [stp_pkg::HANDLE_W-1:0] timer_handle;

    modport source (output valid, output operation, output timer_handle, input ready);
    modport sink   (input valid, input operation, input timer_handle, output ready);
endinterface

// ===== design/stp_rsp_if.sv =====
// response channel carrying one operation result
interface stp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [stp_pkg::HANDLE_W-1:0]  granted_handle;
    logic [stp_pkg::ELAPSED_W-1:0] elapsed;

    modport source (output valid, output status, output granted_handle, output elapsed,
                    input ready);
    modport sink   (input valid, input status, input granted_handle, input elapsed,
                    output ready);
endinterface

// ===== design/stp_cell.sv =====
// one timer cell of the rotating ring: in-use flag and start mark
module stp_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift_en,
    input  stp_pkg::cell_t d_in,
    output stp_pkg::cell_t q
);

    logic                            used_reg;
    logic [stp_pkg::COUNT_WIDTH-1:0] mark_reg;

    // in-use flag clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            used_reg <= d_in.used;
        end
    end

    // start mark, undefined until written
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            mark_reg <= d_in.mark;
        end
    end

    assign q.used = used_reg;
    assign q.mark = mark_reg;

endmodule

// ===== design/stp_head.sv =====
// head unit: applies the current operation to the entry leaving cell zero
module stp_head (
    input  logic                clk,
    input  logic                rst_n,
    input  stp_pkg::walk_ctrl_t ctrl,
    input  stp_pkg::cell_t      cell_in,
    output stp_pkg::cell_t      cell_out,
    output stp_pkg::result_t    result
);

    logic                           found_reg;
    logic [stp_pkg::HANDLE_W-1:0]   granted_reg;
    logic [stp_pkg::ELAPSED_W-1:0]  elapsed_reg;
    logic                           match;
    logic                           grab;
    logic [stp_pkg::COUNT_WIDTH-1:0] diff;

    assign match = (stp_pkg::CMP_W'(ctrl.idx) == stp_pkg::CMP_W'(ctrl.handle));
    assign grab  = (ctrl.op == stp_pkg::OP_ALLOC) && !found_reg && !cell_in.used;
    assign diff  = ctrl.count - cell_in.mark;

    // modify the entry on its way around the ring
    always_comb
    begin
        cell_out = cell_in;
        unique case (ctrl.op)
            stp_pkg::OP_TICK:
            begin
                if (ctrl.rebase && cell_in.used)
                begin
                    cell_out.mark = cell_in.mark - ctrl.rebase_amt;
                end
            end
            stp_pkg::OP_ALLOC:
            begin
                if (grab)
                begin
                    cell_out.used = 1'b1;
                end
            end
            stp_pkg::OP_RESTART:
            begin
                if (match)
                begin
                    cell_out.mark = ctrl.count;
                end
            end
            stp_pkg::OP_READ:
            begin
                cell_out = cell_in;
            end
            default:
            begin
                cell_out = cell_in;
            end
        endcase
    end

    // result collection over the walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            granted_reg <= '0;
            elapsed_reg <= '0;
        end
        else if (ctrl.start)
        begin
            found_reg   <= 1'b0;
            granted_reg <= '0;
            elapsed_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (grab)
            begin
                found_reg   <= 1'b1;
                granted_reg <= stp_pkg::HANDLE_W'(ctrl.idx);
            end
            if ((ctrl.op == stp_pkg::OP_READ) && match)
            begin
                elapsed_reg <= stp_pkg::ELAPSED_W'(diff);
            end
        end
    end

    assign result.status         = (ctrl.op == stp_pkg::OP_ALLOC) && !found_reg;
    assign result.granted_handle = granted_reg;
    assign result.elapsed        = elapsed_reg;

endmodule

// ===== design/software_timer_pool.sv =====
// top level: sequencer, tick counter, ring of timer cells and response register
// sequence: a request is accepted in the idle state, the walk then shifts every timer cell
//   once past the head unit, and the post state loads the response register
// throughput: one request at a time; a new one is taken only back in the idle state,
//   after the ring rotation and the post state, which stalls while a response is untaken
// reset: asynchronous active low; counter zero, all timers free, max_tics 30000,
//   start marks undefined until restarted
module software_timer_pool (
    input  logic                              clk,
    input  logic                              rst_n,
    stp_req_if.sink                           req,
    stp_rsp_if.source                         rsp,
    input  logic                              max_tics_we,
    input  logic [stp_pkg::MAXTICS_W-1:0]     max_tics_wdata
);

    stp_pkg::state_t                 state_reg, state_next;
    logic [stp_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [stp_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic [stp_pkg::MAXTICS_W-1:0]   max_tics_reg;
    stp_pkg::op_t                    op_reg;
    logic [stp_pkg::HANDLE_W-1:0]    handle_reg;
    logic                            rebase_reg;
    logic [stp_pkg::COUNT_WIDTH-1:0] rebase_amt_reg;
    logic                            rsp_valid_reg;
    stp_pkg::result_t                rsp_data_reg;

    logic                            accept;
    logic                            step;
    logic                            load_rsp;
    logic                            req_ready;
    logic [stp_pkg::COUNT_WIDTH-1:0] count_inc;
    logic                            hit_max;

    stp_pkg::walk_ctrl_t             ctrl;
    stp_pkg::cell_t                  head_out;
    stp_pkg::result_t                result;
    stp_pkg::cell_t                  cell_q [stp_pkg::NUM_TIMERS];

    assign accept = req.valid && req_ready;

    // tick arithmetic
    assign count_inc = count_reg + stp_pkg::COUNT_WIDTH'(1);
    assign hit_max   = (stp_pkg::MT_CMP_W'(count_inc) >= stp_pkg::MT_CMP_W'(max_tics_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stp_pkg::ST_WALK;
                end
            end
            stp_pkg::ST_WALK:
            begin
                if (idx_reg == stp_pkg::LAST_IDX)
                begin
                    state_next = stp_pkg::ST_POST;
                end
            end
            stp_pkg::ST_POST:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = stp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stp_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        step      = 1'b0;
        load_rsp  = 1'b0;
        unique case (state_reg)
            stp_pkg::ST_IDLE: req_ready = 1'b1;
            stp_pkg::ST_WALK: step      = 1'b1;
            stp_pkg::ST_POST: load_rsp  = !rsp_valid_reg || rsp.ready;
            default:          req_ready = 1'b0;
        endcase
    end

    // walk index and counter update
    always_comb
    begin
        idx_next = step ? ((idx_reg == stp_pkg::LAST_IDX) ? '0
                                                          : idx_reg + stp_pkg::IDX_W'(1))
                        : '0;
        count_next = count_reg;
        if (accept && (stp_pkg::op_t'(req.operation) == stp_pkg::OP_TICK))
        begin
            count_next = hit_max ? '0 : count_inc;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stp_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            max_tics_reg  <= stp_pkg::MAX_TICS_RESET;
            rebase_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (max_tics_we)
            begin
                max_tics_reg <= max_tics_wdata;
            end
            if (accept)
            begin
                rebase_reg <= (stp_pkg::op_t'(req.operation) == stp_pkg::OP_TICK) && hit_max;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and response payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= stp_pkg::op_t'(req.operation);
            handle_reg     <= req.timer_handle;
            rebase_amt_reg <= count_inc;
        end
        if (load_rsp)
        begin
            rsp_data_reg <= result;
        end
    end

    // head unit control
    assign ctrl.start      = accept;
    assign ctrl.step       = step;
    assign ctrl.op         = op_reg;
    assign ctrl.handle     = handle_reg;
    assign ctrl.idx        = idx_reg;
    assign ctrl.rebase     = rebase_reg;
    assign ctrl.rebase_amt = rebase_amt_reg;
    assign ctrl.count      = count_reg;

    stp_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cell_in  (cell_q[0]),
        .cell_out (head_out),
        .result   (result)
    );

    // ring of cells, each shifting toward cell zero
    for (genvar i = 0; i < stp_pkg::NUM_TIMERS; i++)
    begin : g_cell
        stp_pkg::cell_t d_in;
        if (i == stp_pkg::NUM_TIMERS - 1)
        begin : g_tail
            assign d_in = head_out;
        end
        else
        begin : g_mid
            assign d_in = cell_q[i+1];
        end
        stp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (step),
            .d_in     (d_in),
            .q        (cell_q[i])
        );
    end

    // port drive
    assign req.ready          = req_ready;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_data_reg.status;
    assign rsp.granted_handle = rsp_data_reg.granted_handle;
    assign rsp.elapsed        = rsp_data_reg.elapsed;

    // walk index rests at zero outside a walk so the ring stays aligned
    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stp_pkg::ST_WALK) |-> (idx_reg == '0))
        else $error("walk index not at zero outside walk");

    // an accepted request always starts a walk
    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == stp_pkg::ST_WALK))
        else $error("accepted request did not start walk");

    // a response appears only after the post state
    a_rsp_from_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == stp_pkg::ST_POST))
        else $error("response raised outside post state");

    // the counter moves only on an accepted request
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("tick counter changed without a request");

endmodule

// ===== verif/tb_software_timer_pool.sv =====
// self-checking testbench for the software timer pool, with its own prediction of each response
`timescale 1ns / 1ps

module tb_software_timer_pool;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    // shadow copy of the pool plus the queue of responses still owed
    class timer_result_tracker;
        logic [stp_pkg::COUNT_WIDTH-1:0] shadow_count;
        logic [stp_pkg::COUNT_WIDTH-1:0] shadow_marks [stp_pkg::NUM_TIMERS];
        logic                            shadow_used  [stp_pkg::NUM_TIMERS];
        logic [stp_pkg::MAXTICS_W-1:0]   shadow_max_tics;
        stp_pkg::result_t                expected_results [$];
        int                              errors;

        function new();
            shadow_count    = '0;
            shadow_max_tics = stp_pkg::MAX_TICS_RESET;
            errors          = 0;
            for (int i = 0; i < stp_pkg::NUM_TIMERS; i++)
            begin
                shadow_marks[i] = '0;
                shadow_used[i]  = 1'b0;
            end
        endfunction

        function void set_max_tics(logic [stp_pkg::MAXTICS_W-1:0] value);
            shadow_max_tics = value;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        // apply one accepted request to the shadow state and queue its response
        function void note_request(stp_pkg::op_t op, logic [stp_pkg::HANDLE_W-1:0] handle);
            stp_pkg::result_t outcome;
            bit               granted;
            outcome = '0;
            granted = 1'b0;
            case (op)
                stp_pkg::OP_TICK:
                begin
                    shadow_count = shadow_count + 1'b1;
                    if (shadow_count >= shadow_max_tics)
                    begin
                        // rebase only the timers in use
                        for (int i = 0; i < stp_pkg::NUM_TIMERS; i++)
                            if (shadow_used[i])
                                shadow_marks[i] = shadow_marks[i] - shadow_count;
                        shadow_count = '0;
                    end
                end
                stp_pkg::OP_ALLOC:
                begin
                    outcome.status = 1'b1;
                    for (int i = 0; i < stp_pkg::NUM_TIMERS; i++)
                    begin
                        if (!granted && !shadow_used[i])
                        begin
                            shadow_used[i]         = 1'b1;
                            outcome.status         = 1'b0;
                            outcome.granted_handle = stp_pkg::HANDLE_W'(i);
                            granted                = 1'b1;
                        end
                    end
                end
                stp_pkg::OP_RESTART:
                begin
                    if (handle < stp_pkg::NUM_TIMERS)
                        shadow_marks[handle] = shadow_count;
                end
                default:
                begin
                    if (handle < stp_pkg::NUM_TIMERS)
                        outcome.elapsed = stp_pkg::ELAPSED_W'(shadow_count
                                                              - shadow_marks[handle]);
                end
            endcase
            expected_results.push_back(outcome);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        // compare one accepted response with the oldest expectation
        task check_response(logic status, logic [stp_pkg::HANDLE_W-1:0] granted_handle,
                            logic [stp_pkg::ELAPSED_W-1:0] elapsed);
            stp_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              status, want.status));
                if (granted_handle !== want.granted_handle)
                    report_mismatch($sformatf("granted_handle %0d, expected %0d",
                                              granted_handle, want.granted_handle));
                if (elapsed !== want.elapsed)
                    report_mismatch($sformatf("elapsed %0d, expected %0d",
                                              elapsed, want.elapsed));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic max_tics_we;
    logic [stp_pkg::MAXTICS_W-1:0] max_tics_wdata;

    stp_req_if req_ch ();
    stp_rsp_if rsp_ch ();

    timer_result_tracker tracker = new();

    // marks written by a restart, so reads never touch an undefined mark
    bit mark_written [stp_pkg::NUM_TIMERS];
    bit idle_on;
    bit hold_request;
    int cycle_count;

    software_timer_pool dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .max_tics_we    (max_tics_we),
        .max_tics_wdata (max_tics_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_software_timer_pool: errors");
                $finish;
            end
        end
    end

    // response side: check accepted responses, stall in bursts, one long hold
    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                tracker.check_response(rsp_ch.status, rsp_ch.granted_handle,
                                       rsp_ch.elapsed);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < 15)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(stp_pkg::op_t op, logic [stp_pkg::HANDLE_W-1:0] handle);
        if (idle_on && $urandom_range(0, 99) < 20)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.timer_handle <= handle;
        if (op == stp_pkg::OP_RESTART && handle < stp_pkg::NUM_TIMERS)
            mark_written[handle] = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(op, handle);
    endtask

    // register write once every response is back
    task automatic write_max_tics(logic [stp_pkg::MAXTICS_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        max_tics_we    <= 1'b1;
        max_tics_wdata <= value;
        @(posedge clk);
        max_tics_we <= 1'b0;
        tracker.set_max_tics(value);
    endtask

    // random requests, reads only on timers with a written mark
    task automatic run_random(int count);
        int pick;
        int handle;
        bit any_mark;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            any_mark = 1'b0;
            for (int i = 0; i < stp_pkg::NUM_TIMERS; i++)
                any_mark |= mark_written[i];
            if (pick < 40)
            begin
                send_request(stp_pkg::OP_TICK, stp_pkg::HANDLE_W'($urandom_range(0, 31)));
            end
            else if (pick < 47)
            begin
                send_request(stp_pkg::OP_ALLOC, stp_pkg::HANDLE_W'($urandom_range(0, 31)));
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    handle = $urandom_range(stp_pkg::NUM_TIMERS, 31);
                else
                    handle = $urandom_range(0, stp_pkg::NUM_TIMERS - 1);
                send_request(stp_pkg::OP_RESTART, stp_pkg::HANDLE_W'(handle));
            end
            else
            begin
                if (!any_mark || $urandom_range(0, 9) == 0)
                begin
                    handle = $urandom_range(stp_pkg::NUM_TIMERS, 31);
                end
                else
                begin
                    handle = $urandom_range(0, stp_pkg::NUM_TIMERS - 1);
                    while (!mark_written[handle])
                        handle = $urandom_range(0, stp_pkg::NUM_TIMERS - 1);
                end
                send_request(stp_pkg::OP_READ, stp_pkg::HANDLE_W'(handle));
            end
        end
    endtask

    // main sequence
    initial
    begin
        int phase_max [9];
        int phase_len [9];
        int value;
        phase_max = '{0, 1, 65535, 2, -1, 30000, 5, -1, 7};
        phase_len = '{100, 100, 100, 150, 150, 80, 100, 150, 270};
        for (int i = 0; i < stp_pkg::NUM_TIMERS; i++)
            mark_written[i] = 1'b0;
        idle_on      = 1'b0;
        hold_request = 1'b0;
        rst_n               <= 1'b0;
        max_tics_we         <= 1'b0;
        max_tics_wdata      <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= stp_pkg::OP_TICK;
        req_ch.timer_handle <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: out-of-range handles, unused timers, rebase and wraparound
        write_max_tics(16'd3);
        idle_on = 1'b1;
        send_request(stp_pkg::OP_READ,    5'd31);
        send_request(stp_pkg::OP_RESTART, 5'd31);
        send_request(stp_pkg::OP_ALLOC,   5'd0);
        send_request(stp_pkg::OP_ALLOC,   5'd0);
        send_request(stp_pkg::OP_RESTART, 5'd0);
        send_request(stp_pkg::OP_TICK,    5'd0);
        send_request(stp_pkg::OP_RESTART, 5'd1);
        send_request(stp_pkg::OP_RESTART, 5'd25);
        send_request(stp_pkg::OP_TICK,    5'd31);
        send_request(stp_pkg::OP_READ,    5'd0);
        send_request(stp_pkg::OP_READ,    5'd1);
        // third tick rebases the two timers in use
        send_request(stp_pkg::OP_TICK,    5'd0);
        send_request(stp_pkg::OP_READ,    5'd0);
        send_request(stp_pkg::OP_READ,    5'd1);
        // unused timer keeps its mark, giving the largest elapsed value
        send_request(stp_pkg::OP_READ,    5'd25);
        send_request(stp_pkg::OP_RESTART, 5'd25);
        send_request(stp_pkg::OP_READ,    5'd26);
        send_request(stp_pkg::OP_RESTART, 5'd26);
        send_request(stp_pkg::OP_TICK,    5'd0);
        send_request(stp_pkg::OP_READ,    5'd25);

        // random phases over several max_tics settings, last one without idling
        for (int p = 0; p < 9; p++)
        begin
            value = (phase_max[p] < 0) ? $urandom_range(3, 60) : phase_max[p];
            write_max_tics(stp_pkg::MAXTICS_W'(value));
            idle_on = (p == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 3)
                hold_request = 1'b1;
            run_random(phase_len[p]);
        end

        // drain and finish
        req_ch.valid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_software_timer_pool: clean");
        else
            $display("tb_software_timer_pool: errors");
        $finish;
    end

endmodule
